[hdl/lru_block_cache_with_pinning_defines.svh]
// Assertion helpers for the block cache. All checks are sampled on clk and
// are held off while rst_n is low.
`ifndef LRU_BLOCK_CACHE_WITH_PINNING_DEFINES_SVH
`define LRU_BLOCK_CACHE_WITH_PINNING_DEFINES_SVH

// Same-cycle implication.
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lbc_pkg.sv]
package lbc_pkg;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_PIN    = 3'd2;
  localparam logic [2:0] CMD_UNPIN  = 3'd3;
  localparam logic [2:0] CMD_EVICT  = 3'd4;
  localparam logic [2:0] CMD_INVAL  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOVICTIM = 2'd2;

  // cell write operations
  localparam logic [2:0] WOP_NONE    = 3'd0;
  localparam logic [2:0] WOP_CLR_ALL = 3'd1;
  localparam logic [2:0] WOP_CLEAR   = 3'd2;
  localparam logic [2:0] WOP_PIN     = 3'd3;
  localparam logic [2:0] WOP_UNPIN   = 3'd4;
  localparam logic [2:0] WOP_STAMP   = 3'd5;
  localparam logic [2:0] WOP_UPDATE  = 3'd6;
  localparam logic [2:0] WOP_NEW     = 3'd7;

  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  // wide enough for any supported depth
  typedef logic [7:0] tok_idx_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [31:0] window;
    logic [31:0] dref;
    logic [31:0] samples;
    logic [63:0] start;
    logic [63:0] step;
  } entry_t;

  typedef struct packed {
    logic        found;
    tok_idx_t    found_idx;
    logic        victim_found;
    tok_idx_t    victim_idx;
    logic [31:0] victim_stamp;
    logic        free_found;
    tok_idx_t    free_idx;
  } scan_tok_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  op;
    tok_idx_t    tgt;
    logic [31:0] key;
    logic [31:0] stamp;
    entry_t      entry;
  } cell_wr_t;

endpackage

[hdl/lbc_cell.sv]
module lbc_cell #(
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    cell_idx,
  input  logic [31:0]         scan_key,
  input  lbc_pkg::scan_tok_t  tok_in,
  output lbc_pkg::scan_tok_t  tok_out,
  input  lbc_pkg::cell_wr_t   wr,
  output lbc_pkg::entry_t     entry
);

  logic               valid_r;
  logic               pinned_r;
  logic [31:0]        key_r;
  logic [31:0]        stamp_r;
  lbc_pkg::entry_t    entry_r;
  lbc_pkg::scan_tok_t tok_r;
  lbc_pkg::scan_tok_t tok_nxt;
  lbc_pkg::tok_idx_t  my_idx;
  logic               sel;

  assign my_idx = lbc_pkg::tok_idx_t'(cell_idx);
  assign sel    = wr.en && (wr.tgt == my_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.found && valid_r && key_r == scan_key) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.found_idx = my_idx;
    end
    // strict less-than keeps the lowest index on ties
    if (valid_r && !pinned_r && (!tok_in.victim_found || stamp_r < tok_in.victim_stamp)) begin
      tok_nxt.victim_found = 1'b1;
      tok_nxt.victim_idx   = my_idx;
      tok_nxt.victim_stamp = stamp_r;
    end
    if (!valid_r && !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pinned_r <= 1'b0;
    end else if (wr.en) begin
      case (wr.op)
        lbc_pkg::WOP_CLR_ALL: begin
          valid_r  <= 1'b0;
          pinned_r <= 1'b0;
        end
        lbc_pkg::WOP_CLEAR: begin
          if (sel) begin
            valid_r  <= 1'b0;
            pinned_r <= 1'b0;
          end
        end
        lbc_pkg::WOP_PIN: begin
          if (sel) pinned_r <= 1'b1;
        end
        lbc_pkg::WOP_UNPIN: begin
          if (sel) pinned_r <= 1'b0;
        end
        lbc_pkg::WOP_NEW: begin
          if (sel) begin
            valid_r  <= 1'b1;
            pinned_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (wr.op)
        lbc_pkg::WOP_NEW: begin
          key_r   <= wr.key;
          entry_r <= wr.entry;
          stamp_r <= wr.stamp;
        end
        lbc_pkg::WOP_UPDATE: begin
          entry_r <= wr.entry;
          stamp_r <= wr.stamp;
        end
        lbc_pkg::WOP_STAMP: begin
          stamp_r <= wr.stamp;
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_out = tok_r;
  assign entry   = entry_r;

endmodule

[hdl/lru_block_cache_with_pinning.sv]
// Fully associative block descriptor cache with LRU replacement and pinning.
// Input channel in_*: one command transaction (lookup, insert, pin, unpin,
// evict LRU, invalidate all) with key and payload words. Result channel out_*:
// exactly one result transaction per command with status, the hit payload
// (zero unless a lookup hits), the entry count and the running counters.
// Both channels use valid/stall; a transaction moves when valid && !stall.
// Each entry lives in a cell of a chain. A command's key is broadcast and a
// scan token walks the chain one cell per cycle, collecting the first match,
// the LRU unpinned victim and the lowest free slot. A command passes from
// acceptance through the scan, as the token travels the whole chain, and an
// apply step into the result register; a new command is taken only once the
// previous one is written out, so commands are not overlapped in the chain.
// A result waiting under out_stall holds the block in its apply step; the
// next command may still be accepted while that result sits in the output
// register. Reset (rst_n low, synchronous) empties the cache, clears the
// counters and use clock and sets the generation to one; no clearing pass.
`include "lru_block_cache_with_pinning_defines.svh"

module lru_block_cache_with_pinning #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_block_id,
  input  logic [31:0] in_window_id,
  input  logic [31:0] in_data_ref,
  input  logic [31:0] in_sample_count,
  input  logic [63:0] in_start_pos,
  input  logic [63:0] in_step_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_hit_window_id,
  output logic [31:0] out_hit_data_ref,
  output logic [31:0] out_hit_sample_count,
  output logic [63:0] out_hit_start_pos,
  output logic [63:0] out_hit_step_size,
  output logic [4:0]  out_entry_count,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_eviction_total
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      use_clock_r, use_clock_nxt;
  logic [31:0]      gen_r, gen_nxt;
  logic [31:0]      hits_r, hits_nxt;
  logic [31:0]      misses_r, misses_nxt;
  logic [31:0]      evict_r, evict_nxt;

  logic [2:0]       cmd_r;
  logic [31:0]      key_r;
  lbc_pkg::entry_t  pay_r;

  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  lbc_pkg::entry_t  hit_r, hit_nxt;

  lbc_pkg::scan_tok_t tok_w [ENTRIES+1];
  lbc_pkg::entry_t    ent_w [ENTRIES];
  lbc_pkg::cell_wr_t  wr;
  lbc_pkg::scan_tok_t res;
  lbc_pkg::entry_t    found_ent;
  logic [31:0]        stamp_nxt;
  logic               in_acc;
  logic               exec_go;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign tok_w[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lbc_cell #(.IDX_W(IDX_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .scan_key (key_r),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1]),
      .wr       (wr),
      .entry    (ent_w[i])
    );
  end

  assign res       = tok_w[ENTRIES];
  assign found_ent = ent_w[res.found_idx[IDX_W-1:0]];
  assign stamp_nxt = (use_clock_r == lbc_pkg::STAMP_MAX) ? use_clock_r : use_clock_r + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IDX_W'(ENTRIES - 1)) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    use_clock_nxt = use_clock_r;
    gen_nxt       = gen_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    evict_nxt     = evict_r;
    status_nxt    = lbc_pkg::ST_OK;
    hit_nxt       = '0;
    wr            = '0;
    wr.en         = exec_go;
    wr.op         = lbc_pkg::WOP_NONE;
    wr.key        = key_r;
    wr.stamp      = stamp_nxt;
    wr.entry      = pay_r;
    wr.entry.gen  = gen_r;
    case (cmd_r)
      lbc_pkg::CMD_LOOKUP: begin
        if (res.found && found_ent.gen == gen_r) begin
          wr.op         = lbc_pkg::WOP_STAMP;
          wr.tgt        = res.found_idx;
          use_clock_nxt = stamp_nxt;
          hits_nxt      = hits_r + 32'd1;
          hit_nxt       = found_ent;
          hit_nxt.gen   = '0;
        end else begin
          misses_nxt = misses_r + 32'd1;
          status_nxt = lbc_pkg::ST_NOTFOUND;
        end
      end
      lbc_pkg::CMD_INSERT: begin
        if (res.found) begin
          wr.op         = lbc_pkg::WOP_UPDATE;
          wr.tgt        = res.found_idx;
          use_clock_nxt = stamp_nxt;
        end else if (count_r >= CNT_W'(ENTRIES)) begin
          // full: the new entry replaces the LRU unpinned victim in its slot
          if (res.victim_found) begin
            wr.op         = lbc_pkg::WOP_NEW;
            wr.tgt        = res.victim_idx;
            use_clock_nxt = stamp_nxt;
            evict_nxt     = evict_r + 32'd1;
          end else begin
            status_nxt = lbc_pkg::ST_NOVICTIM;
          end
        end else begin
          wr.op         = lbc_pkg::WOP_NEW;
          wr.tgt        = res.free_idx;
          use_clock_nxt = stamp_nxt;
          count_nxt     = count_r + 1'b1;
        end
      end
      lbc_pkg::CMD_PIN, lbc_pkg::CMD_UNPIN: begin
        if (res.found) begin
          wr.op  = (cmd_r == lbc_pkg::CMD_PIN) ? lbc_pkg::WOP_PIN : lbc_pkg::WOP_UNPIN;
          wr.tgt = res.found_idx;
        end else begin
          status_nxt = lbc_pkg::ST_NOTFOUND;
        end
      end
      lbc_pkg::CMD_EVICT: begin
        if (res.victim_found) begin
          wr.op     = lbc_pkg::WOP_CLEAR;
          wr.tgt    = res.victim_idx;
          evict_nxt = evict_r + 32'd1;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = lbc_pkg::ST_NOVICTIM;
        end
      end
      lbc_pkg::CMD_INVAL: begin
        wr.op     = lbc_pkg::WOP_CLR_ALL;
        count_nxt = '0;
        gen_nxt   = (gen_r == lbc_pkg::STAMP_MAX) ? 32'd1 : gen_r + 32'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      use_clock_r <= '0;
      gen_r       <= 32'd1;
      hits_r      <= '0;
      misses_r    <= '0;
      evict_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (exec_go) begin
        count_r     <= count_nxt;
        use_clock_r <= use_clock_nxt;
        gen_r       <= gen_nxt;
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        evict_r     <= evict_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r         <= in_cmd;
      key_r         <= in_block_id;
      pay_r.gen     <= '0;
      pay_r.window  <= in_window_id;
      pay_r.dref    <= in_data_ref;
      pay_r.samples <= in_sample_count;
      pay_r.start   <= in_start_pos;
      pay_r.step    <= in_step_size;
    end
    if (exec_go) begin
      status_r           <= status_nxt;
      hit_r              <= hit_nxt;
      out_entry_count    <= 5'(count_nxt);
      out_hit_total      <= hits_nxt;
      out_miss_total     <= misses_nxt;
      out_eviction_total <= evict_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_hit_window_id    = hit_r.window;
  assign out_hit_data_ref     = hit_r.dref;
  assign out_hit_sample_count = hit_r.samples;
  assign out_hit_start_pos    = hit_r.start;
  assign out_hit_step_size    = hit_r.step;

  `LBC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(ENTRIES), "entry count above depth")
  `LBC_ASSERT_NEXT(a_acc_scan, in_acc, state_r == S_SCAN, "accepted command did not start scan")
  `LBC_ASSERT_NOW(a_rise_exec, $rose(out_valid_r), $past(state_r) == S_EXEC, "result without apply step")
  `LBC_ASSERT_NOW(a_gen_nonzero, 1'b1, gen_r != 32'd0, "generation reached zero")

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam int NUM_SLOTS = 16;
  localparam int RAND_ITEMS = 1700;
  localparam int QUIET_TAIL = 150;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] win;
    logic [31:0] dref;
    logic [31:0] samples;
    logic [63:0] start;
    logic [63:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] win;
    logic [31:0] dref;
    logic [31:0] samples;
    logic [63:0] start;
    logic [63:0] step;
    logic [4:0]  count;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } result_t;

  typedef struct packed {
    result_t     res;
    logic        fixed;
    logic [1:0]  fixed_status;
    logic [4:0]  fixed_count;
  } pending_t;

  typedef struct packed {
    cmd_t        c;
    logic        fixed;
    logic [1:0]  st;
    logic [4:0]  cnt;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = '0;
  logic [31:0] in_block_id = '0, in_window_id = '0, in_data_ref = '0, in_sample_count = '0;
  logic [63:0] in_start_pos = '0, in_step_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_hit_window_id, out_hit_data_ref, out_hit_sample_count;
  logic [63:0] out_hit_start_pos, out_hit_step_size;
  logic [4:0] out_entry_count;
  logic [31:0] out_hit_total, out_miss_total, out_eviction_total;

  lru_block_cache_with_pinning #(.ENTRIES(NUM_SLOTS)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cache image kept by the predictor
  bit          slot_valid [NUM_SLOTS];
  bit          slot_pinned[NUM_SLOTS];
  logic [31:0] slot_key   [NUM_SLOTS];
  logic [31:0] slot_win   [NUM_SLOTS];
  logic [31:0] slot_dref  [NUM_SLOTS];
  logic [31:0] slot_samp  [NUM_SLOTS];
  logic [63:0] slot_start [NUM_SLOTS];
  logic [63:0] slot_step  [NUM_SLOTS];
  logic [31:0] slot_gen   [NUM_SLOTS];
  logic [31:0] slot_stamp [NUM_SLOTS];
  int unsigned live_count = 0;
  logic [31:0] use_clk = '0, cur_gen = 32'd1;
  logic [31:0] hit_cnt = '0, miss_cnt = '0, evict_cnt = '0;

  pending_t awaiting[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  bit quiet = 0;
  logic [31:0] key_pool[24];

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [31:0] tick_clock();
    if (use_clk != lbc_pkg::STAMP_MAX) use_clk++;
    return use_clk;
  endfunction

  function automatic bit evict_oldest();
    int v;
    v = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!slot_valid[i] || slot_pinned[i]) continue;
      if (v < 0 || slot_stamp[i] < slot_stamp[v]) v = i;
    end
    if (v < 0) return 1'b0;
    slot_valid[v] = 0;
    slot_pinned[v] = 0;
    if (live_count != 0) live_count--;
    evict_cnt++;
    return 1'b1;
  endfunction

  function automatic void fill_slot(int s, cmd_t c);
    slot_win[s] = c.win;
    slot_dref[s] = c.dref;
    slot_samp[s] = c.samples;
    slot_start[s] = c.start;
    slot_step[s] = c.step;
    slot_gen[s] = cur_gen;
    slot_stamp[s] = tick_clock();
  endfunction

  function automatic logic [1:0] cache_insert(cmd_t c);
    int s;
    s = find_key(c.key);
    if (s >= 0) begin
      fill_slot(s, c);
      return lbc_pkg::ST_OK;
    end
    if (live_count >= NUM_SLOTS && !evict_oldest()) return lbc_pkg::ST_NOVICTIM;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (!slot_valid[i]) begin
        s = i;
        break;
      end
    if (s < 0) return lbc_pkg::ST_NOVICTIM;
    slot_valid[s] = 1;
    slot_pinned[s] = 0;
    slot_key[s] = c.key;
    fill_slot(s, c);
    live_count++;
    return lbc_pkg::ST_OK;
  endfunction

  function automatic result_t predict_result(cmd_t c);
    result_t r;
    int s;
    r = '0;
    r.status = lbc_pkg::ST_OK;
    case (c.cmd)
      lbc_pkg::CMD_LOOKUP: begin
        s = find_key(c.key);
        if (s < 0 || slot_gen[s] != cur_gen) begin
          miss_cnt++;
          r.status = lbc_pkg::ST_NOTFOUND;
        end else begin
          slot_stamp[s] = tick_clock();
          hit_cnt++;
          r.win = slot_win[s];
          r.dref = slot_dref[s];
          r.samples = slot_samp[s];
          r.start = slot_start[s];
          r.step = slot_step[s];
        end
      end
      lbc_pkg::CMD_INSERT: r.status = cache_insert(c);
      lbc_pkg::CMD_PIN, lbc_pkg::CMD_UNPIN: begin
        s = find_key(c.key);
        if (s < 0) r.status = lbc_pkg::ST_NOTFOUND;
        else slot_pinned[s] = (c.cmd == lbc_pkg::CMD_PIN);
      end
      lbc_pkg::CMD_EVICT: if (!evict_oldest()) r.status = lbc_pkg::ST_NOVICTIM;
      lbc_pkg::CMD_INVAL: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot_valid[i] = 0;
          slot_pinned[i] = 0;
        end
        live_count = 0;
        cur_gen++;
        if (cur_gen == 0) cur_gen = 32'd1;
      end
      default: ;
    endcase
    r.count = live_count[4:0];
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    return r;
  endfunction

  // fill: 0 all zero payload, 1 all ones, 2 random
  function automatic cmd_t mk(logic [2:0] op, logic [31:0] k, int fill);
    cmd_t c;
    c.cmd = op;
    c.key = k;
    if (fill == 2) begin
      c.win = $urandom;
      c.dref = $urandom;
      c.samples = $urandom;
      c.start = {$urandom, $urandom};
      c.step = {$urandom, $urandom};
    end else begin
      {c.win, c.dref, c.samples, c.start, c.step} = fill ? '1 : '0;
    end
    return c;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d, %s: got %h want %h", received, what, got, want);
    errors++;
  endtask

  task automatic send(cmd_t c, bit fixed, logic [1:0] st, logic [4:0] cnt);
    pending_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_cmd <= c.cmd;
    in_block_id <= c.key;
    in_window_id <= c.win;
    in_data_ref <= c.dref;
    in_sample_count <= c.samples;
    in_start_pos <= c.start;
    in_step_size <= c.step;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p.res = predict_result(c);
    p.fixed = fixed;
    p.fixed_status = st;
    p.fixed_count = cnt;
    awaiting.push_back(p);
    sent++;
    if (sent >= RAND_ITEMS - QUIET_TAIL) quiet = 1;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return key_pool[$urandom_range(0, 23)];
  endfunction

  // fill the cache, pin everything, probe the no-victim paths, then unpin one entry and insert and look up again
  task automatic pinned_full_sequence();
    logic [31:0] base;
    base = $urandom;
    send(mk(lbc_pkg::CMD_INVAL, '0, 2), 1'b0, '0, '0);
    for (int i = 0; i < NUM_SLOTS; i++)
      send(mk(lbc_pkg::CMD_INSERT, base + i, 2), 1'b0, '0, '0);
    for (int i = 0; i < NUM_SLOTS; i++)
      send(mk(lbc_pkg::CMD_PIN, base + i, 2), 1'b0, '0, '0);
    send(mk(lbc_pkg::CMD_INSERT, base + NUM_SLOTS, 2), 1'b1, lbc_pkg::ST_NOVICTIM,
         5'(NUM_SLOTS));
    send(mk(lbc_pkg::CMD_EVICT, '0, 2), 1'b1, lbc_pkg::ST_NOVICTIM, 5'(NUM_SLOTS));
    send(mk(lbc_pkg::CMD_UNPIN, base + $urandom_range(0, NUM_SLOTS - 1), 2), 1'b0, '0, '0);
    send(mk(lbc_pkg::CMD_INSERT, base + NUM_SLOTS, 2), 1'b0, '0, '0);
    send(mk(lbc_pkg::CMD_LOOKUP, base + NUM_SLOTS, 2), 1'b0, '0, '0);
  endtask

  initial begin
    row_t rows[17];
    int r;
    logic [2:0] op;
    rows[0]  = '{mk(lbc_pkg::CMD_LOOKUP, '0, 0), 1'b1, lbc_pkg::ST_NOTFOUND, 5'd0};
    rows[1]  = '{mk(lbc_pkg::CMD_PIN, 32'd5, 0), 1'b1, lbc_pkg::ST_NOTFOUND, 5'd0};
    rows[2]  = '{mk(lbc_pkg::CMD_UNPIN, 32'd5, 0), 1'b1, lbc_pkg::ST_NOTFOUND, 5'd0};
    rows[3]  = '{mk(lbc_pkg::CMD_EVICT, '0, 0), 1'b1, lbc_pkg::ST_NOVICTIM, 5'd0};
    rows[4]  = '{mk(lbc_pkg::CMD_INSERT, '0, 0), 1'b1, lbc_pkg::ST_OK, 5'd1};
    rows[5]  = '{mk(lbc_pkg::CMD_INSERT, '1, 1), 1'b1, lbc_pkg::ST_OK, 5'd2};
    rows[6]  = '{mk(lbc_pkg::CMD_LOOKUP, '1, 0), 1'b0, '0, '0};
    rows[7]  = '{mk(lbc_pkg::CMD_LOOKUP, '0, 1), 1'b0, '0, '0};
    rows[8]  = '{mk(lbc_pkg::CMD_PIN, '0, 0), 1'b1, lbc_pkg::ST_OK, 5'd2};
    rows[9]  = '{mk(lbc_pkg::CMD_EVICT, '0, 0), 1'b1, lbc_pkg::ST_OK, 5'd1};
    rows[10] = '{mk(lbc_pkg::CMD_EVICT, '0, 0), 1'b1, lbc_pkg::ST_NOVICTIM, 5'd1};
    rows[11] = '{mk(lbc_pkg::CMD_UNPIN, '0, 0), 1'b1, lbc_pkg::ST_OK, 5'd1};
    rows[12] = '{mk(lbc_pkg::CMD_INSERT, '0, 2), 1'b1, lbc_pkg::ST_OK, 5'd1};
    rows[13] = '{mk(lbc_pkg::CMD_LOOKUP, '0, 0), 1'b0, '0, '0};
    rows[14] = '{mk(lbc_pkg::CMD_INVAL, '1, 1), 1'b1, lbc_pkg::ST_OK, 5'd0};
    rows[15] = '{mk(lbc_pkg::CMD_LOOKUP, '0, 0), 1'b1, lbc_pkg::ST_NOTFOUND, 5'd0};
    rows[16] = '{mk(CMD_SPARE6, '1, 1), 1'b1, lbc_pkg::ST_OK, 5'd0};
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].c, rows[i].fixed, rows[i].st, rows[i].cnt);
    send(mk(CMD_SPARE7, '0, 0), 1'b1, lbc_pkg::ST_OK, 5'd0);
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 299) == 0) begin
        pinned_full_sequence();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) op = lbc_pkg::CMD_LOOKUP;
        else if (r < 72) op = lbc_pkg::CMD_INSERT;
        else if (r < 82) op = lbc_pkg::CMD_PIN;
        else if (r < 91) op = lbc_pkg::CMD_UNPIN;
        else if (r < 96) op = lbc_pkg::CMD_EVICT;
        else if (r < 98) op = lbc_pkg::CMD_INVAL;
        else op = r[0] ? CMD_SPARE7 : CMD_SPARE6;
        send(mk(op, pick_key(), 2), 1'b0, '0, '0);
      end
    end
    in_valid <= 1'b0;
    while (awaiting.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // result side backpressure, with one long hold to fill the block up
  initial begin
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (!held && received >= 300) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (awaiting.size() == 0) begin
        report("unexpected transaction", out_status, '0);
      end else begin
        p = awaiting.pop_front();
        if (out_status != p.res.status) report("status", out_status, p.res.status);
        if (out_hit_window_id != p.res.win) report("window", out_hit_window_id, p.res.win);
        if (out_hit_data_ref != p.res.dref) report("data_ref", out_hit_data_ref, p.res.dref);
        if (out_hit_sample_count != p.res.samples)
          report("samples", out_hit_sample_count, p.res.samples);
        if (out_hit_start_pos != p.res.start) report("start", out_hit_start_pos, p.res.start);
        if (out_hit_step_size != p.res.step) report("step", out_hit_step_size, p.res.step);
        if (out_entry_count != p.res.count) report("count", out_entry_count, p.res.count);
        if (out_hit_total != p.res.hits) report("hit_total", out_hit_total, p.res.hits);
        if (out_miss_total != p.res.misses) report("miss_total", out_miss_total, p.res.misses);
        if (out_eviction_total != p.res.evicts)
          report("eviction_total", out_eviction_total, p.res.evicts);
        if (p.fixed && out_status != p.fixed_status)
          report("status (directed)", out_status, p.fixed_status);
        if (p.fixed && out_entry_count != p.fixed_count)
          report("count (directed)", out_entry_count, p.fixed_count);
      end
      received++;
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
